// File: sv/bezier_patch_flatness_error_macros.svh
// ---------------------------------------------------------------------------
// Bezier patch flatness error: assertion macros
// Implication checks sampled on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BEZIER_PATCH_FLATNESS_ERROR_MACROS_SVH
`define BEZIER_PATCH_FLATNESS_ERROR_MACROS_SVH

// same-cycle implication
`define BPFE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BPFE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/bpfe_pkg.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: package
// Sizes, register indexes and the controller-to-datapath command.
// ---------------------------------------------------------------------------
`default_nettype none

package bpfe_pkg;

  localparam int MAX_DEGREE  = 15;
  localparam int DEG_W       = 4;
  localparam int STORE_DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int COORD_W     = 32;
  localparam int POINT_W     = 3 * COORD_W;
  localparam int WT_W        = 2 * DEG_W;
  localparam int ACC_W       = COORD_W + WT_W + 2;
  localparam int DIV_STEP    = 4;
  localparam int DIV_W       = ((ACC_W + DIV_STEP) / DIV_STEP) * DIV_STEP;
  localparam int DIV_CYC     = DIV_W / DIV_STEP;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int RT_CYC      = SQ_W / 2;
  localparam int ERR_W       = 32;

  typedef enum logic [0:0] {
    REG_DEGREE_U = 1'b0,
    REG_DEGREE_V = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              corner_ld;
    logic [1:0]        corner_sel;
    logic              pt_ld;
    logic [1:0]        comp;
    logic [2:0]        term;
    logic              mac;
    logic              div_init;
    logic              div_step;
    logic              sq_mul;
    logic              twist_sel;
    logic              sq_clr;
    logic              sq_add;
    logic              best_clr;
    logic              best_upd;
    logic              rt_init;
    logic              rt_step;
    logic              interp_ld;
    logic              twist_ld;
    logic              out_ld;
    logic              bad;
    logic [DEG_W-1:0]  row;
    logic [DEG_W-1:0]  col;
    logic [DEG_W-1:0]  deg_u;
    logic [DEG_W-1:0]  deg_v;
  } bpfe_cmd_t;

endpackage

`default_nettype wire

// File: sv/bpfe_ctrl.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: controller
// Degree registers, point count and the evaluation sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module bpfe_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_index_i,
  input  wire logic [bpfe_pkg::DEG_W-1:0] cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output bpfe_pkg::bpfe_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_CLD  = 4'd2;
  localparam logic [3:0] S_PRD  = 4'd3;
  localparam logic [3:0] S_PLD  = 4'd4;
  localparam logic [3:0] S_MAC  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_RT1  = 4'd10;
  localparam logic [3:0] S_TSQ  = 4'd11;
  localparam logic [3:0] S_TADD = 4'd12;
  localparam logic [3:0] S_RT2  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  localparam int AW = bpfe_pkg::ADDR_W;
  localparam int CW = bpfe_pkg::CNT_W;
  localparam int DW = bpfe_pkg::DEG_W;

  logic [3:0]    state_q, state_d;
  logic [DW-1:0] deg_u_q, deg_v_q;
  logic [CW-1:0] count_q, count_d, count_inc;
  logic [CW-1:0] expected;
  logic [DW-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]    comp_q, comp_d, k_q, k_d;
  logic [2:0]    term_q, term_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          bad_q, bad_d, bad_now;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic [AW-1:0] row_base, pt_addr, corner_addr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  assign count_inc = (count_q < CW'(bpfe_pkg::STORE_DEPTH + 1)) ? count_q + 1'b1 : count_q;
  assign expected  = CW'(({5'd0, deg_u_q} + 9'd1) * ({5'd0, deg_v_q} + 9'd1));
  assign bad_now   = (deg_u_q == '0) || (deg_v_q == '0) || (count_inc != expected);

  assign row_base = AW'({4'd0, row_q} * ({4'd0, deg_v_q} + 8'd1));
  assign pt_addr  = row_base + AW'(col_q);

  always_comb begin
    unique case (k_q)
      2'd0:    corner_addr = '0;
      2'd1:    corner_addr = AW'(deg_v_q);
      2'd2:    corner_addr = AW'({4'd0, deg_u_q} * ({4'd0, deg_v_q} + 8'd1));
      default: corner_addr = AW'({4'd0, deg_u_q} * ({4'd0, deg_v_q} + 8'd1)) + AW'(deg_v_q);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    row_d       = row_q;
    col_d       = col_q;
    comp_d      = comp_q;
    k_d         = k_q;
    term_d      = term_q;
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o            = '0;
    cmd_o.wr_addr    = count_q[AW-1:0];
    cmd_o.corner_sel = k_q;
    cmd_o.comp       = comp_q;
    cmd_o.term       = term_q;
    cmd_o.bad        = bad_q;
    cmd_o.row        = row_q;
    cmd_o.col        = col_q;
    cmd_o.deg_u      = deg_u_q;
    cmd_o.deg_v      = deg_v_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.mem_we = (count_q < CW'(bpfe_pkg::STORE_DEPTH));
          count_d      = count_inc;
          if (in_last_i) begin
            count_d = '0;
            bad_d   = bad_now;
            k_d     = '0;
            state_d = bad_now ? S_DONE : S_CRD;
          end
        end
      end
      S_CRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_addr  = corner_addr;
        cmd_o.best_clr = 1'b1;
        state_d        = S_CLD;
      end
      S_CLD: begin
        cmd_o.corner_ld = 1'b1;
        if (k_q == 2'd3) begin
          row_d   = '0;
          col_d   = '0;
          state_d = S_PRD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_PRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = pt_addr;
        state_d       = S_PLD;
      end
      S_PLD: begin
        cmd_o.pt_ld  = 1'b1;
        cmd_o.sq_clr = 1'b1;
        comp_d       = '0;
        term_d       = '0;
        state_d      = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        if (term_q == 3'd4) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          term_d = term_q + 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_init = (cnt_q == '0);
        cmd_o.div_step = (cnt_q != '0);
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == 6'(bpfe_pkg::DIV_CYC)) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_ADD;
      end
      S_ADD: begin
        cmd_o.sq_add = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = S_CMP;
        end else begin
          comp_d  = comp_q + 1'b1;
          term_d  = '0;
          state_d = S_MAC;
        end
      end
      S_CMP: begin
        cmd_o.best_upd = 1'b1;
        if (col_q == deg_v_q) begin
          col_d = '0;
          if (row_q == deg_u_q) begin
            cnt_d   = '0;
            state_d = S_RT1;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = S_PRD;
          end
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_PRD;
        end
      end
      S_RT1: begin
        cmd_o.rt_init = (cnt_q == '0);
        cmd_o.rt_step = (cnt_q != '0) && (cnt_q <= 6'(bpfe_pkg::RT_CYC));
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == 6'(bpfe_pkg::RT_CYC + 1)) begin
          cmd_o.interp_ld = 1'b1;
          cmd_o.sq_clr    = 1'b1;
          comp_d          = '0;
          state_d         = S_TSQ;
        end
      end
      S_TSQ: begin
        cmd_o.sq_mul    = 1'b1;
        cmd_o.twist_sel = 1'b1;
        state_d         = S_TADD;
      end
      S_TADD: begin
        cmd_o.sq_add = 1'b1;
        if (comp_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_RT2;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_TSQ;
        end
      end
      S_RT2: begin
        cmd_o.twist_sel = 1'b1;
        cmd_o.rt_init   = (cnt_q == '0);
        cmd_o.rt_step   = (cnt_q != '0) && (cnt_q <= 6'(bpfe_pkg::RT_CYC));
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == 6'(bpfe_pkg::RT_CYC + 1)) begin
          cmd_o.twist_ld = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      deg_u_q     <= DW'(3);
      deg_v_q     <= DW'(3);
      count_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      comp_q      <= '0;
      k_q         <= '0;
      term_q      <= '0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      row_q       <= row_d;
      col_q       <= col_d;
      comp_q      <= comp_d;
      k_q         <= k_d;
      term_q      <= term_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bpfe_pkg::REG_DEGREE_U: deg_u_q <= cfg_data_i;
          bpfe_pkg::REG_DEGREE_V: deg_v_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/bpfe_dpath.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: datapath
// Point store, offset accumulator, divider, squarer and square root unit.
// ---------------------------------------------------------------------------
`default_nettype none

module bpfe_dpath (
  input  wire logic                          clk_i,
  input  bpfe_pkg::bpfe_cmd_t                cmd_i,
  input  wire logic [bpfe_pkg::POINT_W-1:0]  wr_data_i,
  output logic [bpfe_pkg::ERR_W-1:0]         total_o,
  output logic [bpfe_pkg::ERR_W-1:0]         interp_o,
  output logic [bpfe_pkg::ERR_W-1:0]         twist_o,
  output logic                               mismatch_o
);

  localparam int CW  = bpfe_pkg::COORD_W;
  localparam int WW  = bpfe_pkg::WT_W;
  localparam int AW  = bpfe_pkg::ACC_W;
  localparam int VW  = bpfe_pkg::DIV_W;
  localparam int QW  = bpfe_pkg::SQ_W;
  localparam int EW  = bpfe_pkg::ERR_W;

  logic [bpfe_pkg::POINT_W-1:0] mem [bpfe_pkg::STORE_DEPTH];
  logic [bpfe_pkg::POINT_W-1:0] rd_q;

  logic signed [CW-1:0] corner_q [4][3];
  logic signed [CW-1:0] pt_q [3];
  logic [WW-1:0]        w_q [5];
  logic [bpfe_pkg::DEG_W-1:0] mi, nj;

  logic signed [CW-1:0]   mac_val;
  logic [WW-1:0]          mac_w;
  logic signed [CW+WW:0]  mac_prod;
  logic signed [AW-1:0]   acc_q;
  logic [AW-1:0]          acc_mag;

  logic [VW-1:0] div_q, div_d;
  logic [WW-1:0] rem_q, rem_d;
  logic [WW:0]   div_r;

  logic signed [CW+2:0] tw_t;
  logic [CW+2:0]        tw_mag, tw_rnd;
  logic [CW-1:0]        sq_opnd;
  logic [QW-1:0]        sq_prod;
  logic [QW-1:0]        sqterm_q, sq_q, best_q;

  logic [QW-1:0] rx_q, rres_q, rbit_q;
  logic [QW:0]   rt_sum, rt_rnd;
  logic [EW-1:0] rt_res;
  logic [EW-1:0] interp_q, twist_q;
  logic [EW:0]   total_sum;

  logic [EW-1:0] total_q, out_interp_q, out_twist_q;
  logic          mismatch_q;

  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[QW] ? '1 : s[QW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[cmd_i.wr_addr] <= wr_data_i;
    if (cmd_i.rd_en) rd_q <= mem[cmd_i.rd_addr];
  end

  assign mi = cmd_i.deg_u - cmd_i.row;
  assign nj = cmd_i.deg_v - cmd_i.col;

  always_comb begin
    if (cmd_i.term == 3'd0) begin
      mac_val = pt_q[cmd_i.comp];
    end else begin
      mac_val = corner_q[2'(cmd_i.term - 3'd1)][cmd_i.comp];
    end
    mac_w    = w_q[cmd_i.term];
    mac_prod = $signed({1'b0, mac_w}) * mac_val;
    acc_mag  = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  end

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    div_r = '0;
    for (int s = 0; s < bpfe_pkg::DIV_STEP; s++) begin
      div_r = {rem_d, div_d[VW-1]};
      div_d = {div_d[VW-2:0], 1'b0};
      if (div_r >= {1'b0, w_q[0]}) begin
        rem_d    = WW'(div_r - {1'b0, w_q[0]});
        div_d[0] = 1'b1;
      end else begin
        rem_d = div_r[WW-1:0];
      end
    end
  end

  always_comb begin
    tw_t = (CW+3)'(corner_q[0][cmd_i.comp]) - (CW+3)'(corner_q[1][cmd_i.comp])
         + (CW+3)'(corner_q[3][cmd_i.comp]) - (CW+3)'(corner_q[2][cmd_i.comp]);
    tw_mag  = tw_t[CW+2] ? (CW+3)'(-tw_t) : (CW+3)'(tw_t);
    tw_rnd  = tw_mag + (CW+3)'(2);
    sq_opnd = cmd_i.twist_sel ? tw_rnd[CW+1:2] : div_q[CW-1:0];
    sq_prod = sq_opnd * sq_opnd;
  end

  assign rt_sum    = {1'b0, rres_q} + {1'b0, rbit_q};
  assign rt_rnd    = (rx_q > rres_q) ? {1'b0, rres_q} + 1'b1 : {1'b0, rres_q};
  assign rt_res    = (|rt_rnd[QW:EW]) ? '1 : rt_rnd[EW-1:0];
  assign total_sum = {1'b0, interp_q} + {1'b0, twist_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.corner_ld) begin
      corner_q[cmd_i.corner_sel][0] <= rd_q[CW-1:0];
      corner_q[cmd_i.corner_sel][1] <= rd_q[2*CW-1:CW];
      corner_q[cmd_i.corner_sel][2] <= rd_q[3*CW-1:2*CW];
    end
    if (cmd_i.pt_ld) begin
      pt_q[0] <= rd_q[CW-1:0];
      pt_q[1] <= rd_q[2*CW-1:CW];
      pt_q[2] <= rd_q[3*CW-1:2*CW];
      w_q[0]  <= WW'(cmd_i.deg_u) * WW'(cmd_i.deg_v);
      w_q[1]  <= WW'(mi) * WW'(nj);
      w_q[2]  <= WW'(mi) * WW'(cmd_i.col);
      w_q[3]  <= WW'(cmd_i.row) * WW'(nj);
      w_q[4]  <= WW'(cmd_i.row) * WW'(cmd_i.col);
    end
    if (cmd_i.mac) begin
      acc_q <= (cmd_i.term == 3'd0) ? AW'(mac_prod) : acc_q - AW'(mac_prod);
    end
    if (cmd_i.div_init) begin
      div_q <= VW'(acc_mag) + VW'(w_q[0] >> 1);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
    if (cmd_i.sq_mul) begin
      sqterm_q <= (!cmd_i.twist_sel && |div_q[VW-1:CW]) ? '1 : sq_prod;
    end
    if (cmd_i.sq_clr) begin
      sq_q <= '0;
    end else if (cmd_i.sq_add) begin
      sq_q <= sat_add(sq_q, sqterm_q);
    end
    if (cmd_i.best_clr) begin
      best_q <= '0;
    end else if (cmd_i.best_upd && (sq_q > best_q)) begin
      best_q <= sq_q;
    end
    if (cmd_i.rt_init) begin
      rx_q   <= cmd_i.twist_sel ? sq_q : best_q;
      rres_q <= '0;
      rbit_q <= QW'(1) << (QW - 2);
    end else if (cmd_i.rt_step) begin
      if ({1'b0, rx_q} >= rt_sum) begin
        rx_q   <= rx_q - rt_sum[QW-1:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end
    if (cmd_i.interp_ld) interp_q <= rt_res;
    if (cmd_i.twist_ld) twist_q <= rt_res;
    if (cmd_i.out_ld) begin
      mismatch_q <= cmd_i.bad;
      if (cmd_i.bad) begin
        total_q      <= '0;
        out_interp_q <= '0;
        out_twist_q  <= '0;
      end else begin
        total_q      <= total_sum[EW] ? '1 : total_sum[EW-1:0];
        out_interp_q <= interp_q;
        out_twist_q  <= twist_q;
      end
    end
  end

  assign total_o    = total_q;
  assign interp_o   = out_interp_q;
  assign twist_o    = out_twist_q;
  assign mismatch_o = mismatch_q;

endmodule

`default_nettype wire

// File: sv/bezier_patch_flatness_error.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: top level
// Loads a control grid and reports its distance from the bilinear corner
// surface plus a quarter of the corner twist length.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata x,y,z; tlast last point
//   m_axis    out  tvalid/tready        tdata total,interp,twist; tuser mismatch
//   cfg       in   cfg_we_i             cfg_index_i, cfg_data_i
//
// Points load one per cycle, while no walk runs, into a 256-entry store.
// The last point starts a walk: the four corners, then per point a read and, per
// component, a five-term sum, divide, square and add; then a square root, twist
// squaring and a second square root; a wrong count skips straight to the result.
// Input is held off during the walk; a pending result stalls only the walk end.
// Reset clears control state; the store needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bezier_patch_flatness_error_macros.svh"

module bezier_patch_flatness_error (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  wire logic        s_axis_tlast,   // last_point
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // total_error, interp_error, twist_error
  output logic             m_axis_tuser    // count_mismatch
);

  bpfe_pkg::bpfe_cmd_t cmd;
  logic [31:0] total, interp, twist;

  bpfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  bpfe_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .wr_data_i  (s_axis_tdata),
    .total_o    (total),
    .interp_o   (interp),
    .twist_o    (twist),
    .mismatch_o (m_axis_tuser)
  );

  assign m_axis_tdata = {twist, interp, total};

  `BPFE_ASSERT_IMP(a_mismatch_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `BPFE_ASSERT_IMP(a_total_bound, m_axis_tvalid, (total >= interp) && (total >= twist))
  `BPFE_ASSERT_NXT(a_walk_holds_input, s_axis_tvalid && s_axis_tready && s_axis_tlast,
                   !s_axis_tready)

endmodule

`default_nettype wire

// File: test/bpfe_checker.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: result checker
// Watches the point and result streams, predicts each result from the
// accepted points and configuration writes, and compares field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module bpfe_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  wire logic        s_axis_tlast,   // last_point
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [95:0] m_axis_tdata,   // total_error, interp_error, twist_error
  input  wire logic        m_axis_tuser,   // count_mismatch
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] interp;
    logic [31:0] twist;
    logic        mismatch;
  } flat_res_t;

  logic [3:0]         deg_u_q, deg_v_q;
  logic signed [31:0] grid_x [bpfe_pkg::STORE_DEPTH];
  logic signed [31:0] grid_y [bpfe_pkg::STORE_DEPTH];
  logic signed [31:0] grid_z [bpfe_pkg::STORE_DEPTH];
  int                 pts_seen;
  flat_res_t          flat_q [$];

  assign pending_o = flat_q.size();

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] isqrt_rnd(logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    if (x > res) res += 1;
    return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic signed [31:0] coord(int idx, int k);
    return (k == 0) ? grid_x[idx] : (k == 1) ? grid_y[idx] : grid_z[idx];
  endfunction

  function automatic flat_res_t flatness(int m, int n);
    flat_res_t r;
    int w, c0n, cm0, cmn, idx;
    logic signed [63:0] num, tw;
    logic [63:0] mn, d, d2, sq, best, tsum, q;
    logic [32:0] tot;
    w = n + 1; c0n = n; cm0 = m * w; cmn = m * w + n;
    mn = m * n;
    best = 0;
    for (int i = 0; i <= m; i++) begin
      for (int j = 0; j <= n; j++) begin
        idx = i * w + j;
        sq = 0;
        for (int k = 0; k < 3; k++) begin
          num = $signed(mn) * coord(idx, k)
              - 64'(signed'((m - i) * (n - j))) * coord(0, k)
              - 64'(signed'((m - i) * j)) * coord(c0n, k)
              - 64'(signed'(i * (n - j))) * coord(cm0, k)
              - 64'(signed'(i * j)) * coord(cmn, k);
          d = (mag(num) + mn / 2) / mn;
          d2 = (d > 64'hFFFF_FFFF) ? '1 : d * d;
          sq = sat_sum(sq, d2);
        end
        if (sq > best) best = sq;
      end
    end
    tsum = 0;
    for (int k = 0; k < 3; k++) begin
      tw = 64'(coord(0, k)) - coord(c0n, k) + coord(cmn, k) - coord(cm0, k);
      q = (mag(tw) + 2) / 4;
      tsum = tsum + q * q;
    end
    r.interp = isqrt_rnd(best);
    r.twist = isqrt_rnd(tsum);
    tot = {1'b0, r.interp} + {1'b0, r.twist};
    r.total = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
    r.mismatch = 1'b0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    flat_res_t want, got;
    int m, n;
    if (!rst_ni) begin
      deg_u_q <= 4'd3;
      deg_v_q <= 4'd3;
      pts_seen = 0;
      flat_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == bpfe_pkg::REG_DEGREE_U) deg_u_q <= cfg_data_i;
        else deg_v_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (pts_seen < bpfe_pkg::STORE_DEPTH) begin
          grid_x[pts_seen] = s_axis_tdata[31:0];
          grid_y[pts_seen] = s_axis_tdata[63:32];
          grid_z[pts_seen] = s_axis_tdata[95:64];
        end
        if (pts_seen < bpfe_pkg::STORE_DEPTH + 1) pts_seen++;
        if (s_axis_tlast) begin
          m = deg_u_q; n = deg_v_q;
          if (m == 0 || n == 0 || pts_seen != (m + 1) * (n + 1)) begin
            want = '0;
            want.mismatch = 1'b1;
          end else begin
            want = flatness(m, n);
          end
          flat_q.push_back(want);
          pts_seen = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
        if (flat_q.size() == 0) begin
          report("unexpected result", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = flat_q.pop_front();
          if (got.total !== want.total) report("total", got.total, want.total);
          if (got.interp !== want.interp) report("interp", got.interp, want.interp);
          if (got.twist !== want.twist) report("twist", got.twist, want.twist);
          if (got.mismatch !== want.mismatch)
            report("count_mismatch", 32'(got.mismatch), 32'(want.mismatch));
        end
      end
    end
  end
endmodule

`default_nettype wire

// File: test/tb.sv
// ---------------------------------------------------------------------------
// Bezier patch flatness error: testbench top
// Streams control grids of several degrees with random and extreme coordinates, short
// and long grids, under random idling on both sides; the checker compares.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int IDLE_LIMIT = 100000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [95:0] m_axis_tdata;
  int          fail_count, pending;
  int          src_idle_pct, snk_idle_pct;
  int          items_sent, quiet_cycles;

  bezier_patch_flatness_error u_top (.*);

  bpfe_checker u_chk (
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .*
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      3: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [95:0] data, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_grid(int count, int mode);
    logic [95:0] d;
    for (int k = 0; k < count; k++) begin
      case (mode)
        1: d = {96{1'b1}};
        2: d = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        3: d = (k % 2) ? {3{32'h7FFF_FFFF}} : {3{32'h8000_0000}};
        default: d = {rand_coord(), rand_coord(), rand_coord()};
      endcase
      send_point(d, k == count - 1);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_degrees(logic [3:0] du, logic [3:0] dv);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= bpfe_pkg::REG_DEGREE_U; cfg_data_i <= du;
    @(posedge clk_i);
    cfg_index_i <= bpfe_pkg::REG_DEGREE_V; cfg_data_i <= dv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int du, dv, full, cnt;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = bpfe_pkg::REG_DEGREE_U; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    src_idle_pct = 36; snk_idle_pct = 70;
    items_sent = 0; quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_grid(16, 0);
    send_grid(16, 3);
    send_grid(1, 0);
    set_degrees(4'd1, 4'd1);
    send_grid(4, 1);
    send_grid(4, 2);
    send_grid(4, 3);
    send_grid(5, 0);
    set_degrees(4'd0, 4'd2);
    send_grid(3, 0);

    while (items_sent < 1420) begin
      if (items_sent > 1300) begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end else if (items_sent > 650) begin
        src_idle_pct = 70; snk_idle_pct = 36;
      end
      du = ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 4);
      dv = ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 4);
      if (du == 15 && dv == 15 && $urandom_range(3) != 0) dv = 2;
      set_degrees(du, dv);
      full = (du + 1) * (dv + 1);
      for (int p = 0; p < 3; p++) begin
        cnt = full;
        if ($urandom_range(9) == 0)
          cnt = ($urandom_range(1) && full > 1) ? $urandom_range(1, full - 1)
                                                : full + $urandom_range(1, 3);
        send_grid(cnt, ($urandom_range(19) == 0) ? 3 : 0);
      end
    end
    src_idle_pct = 0; snk_idle_pct = 0;
    set_degrees(4'd15, 4'd15);
    send_grid(256, 0);
    send_grid(258, 0);

    while (pending != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/bpfe_pkg.sv
sv/bpfe_ctrl.sv
sv/bpfe_dpath.sv
sv/bezier_patch_flatness_error.sv
test/bpfe_checker.sv
test/tb.sv
